@@ rtl/core/rrbm_pkg.sv @@
// ----------------------------------------------------------------------------
// rrbm_pkg
// Shared types and constants for the region reference bit matrix.
// ----------------------------------------------------------------------------
package rrbm_pkg;

  localparam int REGION_COUNT = 64;
  localparam int VOLUME_COUNT = 1024;

  localparam int MODE_W   = 3;
  localparam int REGION_W = 6;
  localparam int VOLUME_W = 10;
  localparam int BIT_W    = 6;
  localparam int MASK_W   = 64;
  localparam int ADDR_W   = REGION_W + VOLUME_W;

  localparam logic [VOLUME_W-1:0] VOLUME_LAST = VOLUME_W'(VOLUME_COUNT - 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_SET   = 3'd0,
    MODE_TEST  = 3'd1,
    MODE_READ  = 3'd2,
    MODE_WRITE = 3'd3,
    MODE_CLEAR = 3'd4,
    MODE_FIND  = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISP,
    ST_RD,
    ST_CHK,
    ST_WR,
    ST_CLR,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic capture;
    logic init_write;
    logic rd_issue;
    logic scan_inc;
    logic wr_set;
    logic wr_mask;
    logic clr_write;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic              init_last;
    logic              scan_last;
    logic              hit;
    logic              pair_ok;
    logic              region_ok;
    logic              out_busy;
    logic [MODE_W-1:0] mode;
  } status_t;

endpackage

@@ rtl/core/rrbm_ctrl.sv @@
// ----------------------------------------------------------------------------
// rrbm_ctrl
// Sequencer: clearing pass, dispatch, memory walks and result hand-off.
// ----------------------------------------------------------------------------
module rrbm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rrbm_pkg::status_t status_i,
  output rrbm_pkg::cmd_t    cmd_o
);
  import rrbm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (status_i.init_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISP;
      end
      ST_DISP: begin
        case (status_i.mode)
          MODE_SET, MODE_TEST, MODE_READ, MODE_FIND: begin
            state_d = status_i.pair_ok ? ST_RD : ST_OUT;
          end
          MODE_WRITE: begin
            state_d = status_i.pair_ok ? ST_WR : ST_OUT;
          end
          MODE_CLEAR: begin
            state_d = status_i.region_ok ? ST_CLR : ST_OUT;
          end
          default: begin
            state_d = ST_OUT;
          end
        endcase
      end
      ST_RD: begin
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (status_i.mode == MODE_FIND && !status_i.hit && !status_i.scan_last) begin
          state_d = ST_RD;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_WR: begin
        state_d = ST_OUT;
      end
      ST_CLR: begin
        if (status_i.scan_last) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!status_i.out_busy) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_INIT: begin
        cmd_o.init_write = 1'b1;
      end
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_RD: begin
        cmd_o.rd_issue = 1'b1;
      end
      ST_CHK: begin
        cmd_o.wr_set   = (status_i.mode == MODE_SET);
        cmd_o.scan_inc = (status_i.mode == MODE_FIND) && !status_i.hit &&
                         !status_i.scan_last;
      end
      ST_WR: begin
        cmd_o.wr_mask = 1'b1;
      end
      ST_CLR: begin
        cmd_o.clr_write = 1'b1;
        cmd_o.scan_inc  = !status_i.scan_last;
      end
      ST_OUT: begin
        cmd_o.res_load = !status_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

@@ rtl/core/rrbm_datapath.sv @@
// ----------------------------------------------------------------------------
// rrbm_datapath
// Mask memory, beat capture, walk counter and output register.
// ----------------------------------------------------------------------------
module rrbm_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rrbm_pkg::cmd_t                cmd_i,
  output rrbm_pkg::status_t             status_o,
  input  logic [rrbm_pkg::MODE_W-1:0]   mode_i,
  input  logic [rrbm_pkg::REGION_W-1:0] local_region_i,
  input  logic [rrbm_pkg::VOLUME_W-1:0] target_volume_i,
  input  logic [rrbm_pkg::BIT_W-1:0]    target_region_i,
  input  logic [rrbm_pkg::MASK_W-1:0]   new_mask_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [rrbm_pkg::MASK_W-1:0]   mask_out_o,
  output logic                          bit_hit_o,
  output logic [rrbm_pkg::VOLUME_W-1:0] volume_out_o,
  output logic                          volume_found_o
);
  import rrbm_pkg::*;

  logic [MASK_W-1:0]   mem_q [2**ADDR_W];

  logic [MODE_W-1:0]   mode_q;
  logic [REGION_W-1:0] region_q;
  logic [VOLUME_W-1:0] volume_q;
  logic [BIT_W-1:0]    bitpos_q;
  logic [MASK_W-1:0]   newmask_q;
  logic [VOLUME_W-1:0] scan_q;
  logic [ADDR_W-1:0]   init_q;
  logic [MASK_W-1:0]   rdata_q;

  logic                out_valid_q;
  logic [MASK_W-1:0]   mask_out_q;
  logic                bit_hit_q;
  logic [VOLUME_W-1:0] volume_out_q;
  logic                found_q;

  logic                region_ok, pair_ok, hit;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr, row_addr;
  logic [MASK_W-1:0]   wr_data;

  assign region_ok = int'(region_q) < REGION_COUNT;
  assign pair_ok   = region_ok && (int'(volume_q) < VOLUME_COUNT);
  assign hit       = |rdata_q;
  assign row_addr  = {region_q, scan_q};

  // capture and walk counter
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q    <= mode_i;
      region_q  <= local_region_i;
      volume_q  <= target_volume_i;
      bitpos_q  <= target_region_i;
      newmask_q <= new_mask_i;
      scan_q    <= (mode_i == MODE_CLEAR) ? '0 : target_volume_i;
    end else if (cmd_i.scan_inc) begin
      scan_q <= scan_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
    end else if (cmd_i.init_write) begin
      init_q <= init_q + 1'b1;
    end
  end

  // memory
  assign wr_en   = cmd_i.init_write | cmd_i.wr_set | cmd_i.wr_mask | cmd_i.clr_write;
  assign wr_addr = cmd_i.init_write ? init_q : row_addr;

  always_comb begin
    wr_data = '0;
    if (cmd_i.wr_set) begin
      wr_data = rdata_q | (MASK_W'(1) << bitpos_q);
    end else if (cmd_i.wr_mask) begin
      wr_data = newmask_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) rdata_q <= mem_q[row_addr];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      mask_out_q   <= (mode_q == MODE_READ && pair_ok) ? rdata_q : '0;
      bit_hit_q    <= (mode_q == MODE_TEST) && pair_ok && rdata_q[bitpos_q];
      found_q      <= (mode_q == MODE_FIND) && pair_ok && hit;
      volume_out_q <= ((mode_q == MODE_FIND) && pair_ok && hit) ? scan_q : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mask_out_o     = mask_out_q;
  assign bit_hit_o      = bit_hit_q;
  assign volume_out_o   = volume_out_q;
  assign volume_found_o = found_q;

  assign status_o.init_last = &init_q;
  assign status_o.scan_last = (scan_q == VOLUME_LAST);
  assign status_o.hit       = hit;
  assign status_o.pair_ok   = pair_ok;
  assign status_o.region_ok = region_ok;
  assign status_o.out_busy  = out_valid_q && out_stall_i;
  assign status_o.mode      = mode_q;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a pending beat");

  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.rd_issue && wr_en))
    else $error("memory read and write issued together");

  a_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_inc |-> (scan_q != VOLUME_LAST))
    else $error("volume walk wrapped");

  a_init_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.init_write && (&init_q)) |=> !cmd_i.init_write)
    else $error("clearing pass ran past the last entry");
`endif

endmodule

@@ rtl/core/region_reference_bit_matrix.sv @@
// ----------------------------------------------------------------------------
// region_reference_bit_matrix
// 64-bit target-region masks per (local region, target volume) pair.
// ----------------------------------------------------------------------------
// Sequence: capture, dispatch, then a registered read and check (set, test,
//   read), a store (write), none (spare), a zeroing region walk (clear) or
//   a find walk of up to 1024 volumes, a read and a zero check each.
// Throughput: one item in flight; the next input beat is taken once the
//   result sits in the output register. Reset: a clearing pass zeroes all
//   65536 entries, one per cycle, and holds off input until it finishes.
// ----------------------------------------------------------------------------
module region_reference_bit_matrix (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input beat
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rrbm_pkg::MODE_W-1:0]   mode_i,
  input  logic [rrbm_pkg::REGION_W-1:0] local_region_i,
  input  logic [rrbm_pkg::VOLUME_W-1:0] target_volume_i,
  input  logic [rrbm_pkg::BIT_W-1:0]    target_region_i,
  input  logic [rrbm_pkg::MASK_W-1:0]   new_mask_i,
  // result beat
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rrbm_pkg::MASK_W-1:0]   mask_out_o,
  output logic                          bit_hit_o,
  output logic [rrbm_pkg::VOLUME_W-1:0] volume_out_o,
  output logic                          volume_found_o
);
  import rrbm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: owns the input handshake and drives one command set per cycle.
  rrbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: mask memory (single write, single registered read port),
  // captured beat, volume walk counter and the output register that parts
  // the result side from the input side.
  rrbm_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .mode_i          (mode_i),
    .local_region_i  (local_region_i),
    .target_volume_i (target_volume_i),
    .target_region_i (target_region_i),
    .new_mask_i      (new_mask_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .mask_out_o      (mask_out_o),
    .bit_hit_o       (bit_hit_o),
    .volume_out_o    (volume_out_o),
    .volume_found_o  (volume_found_o)
  );

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for region_reference_bit_matrix. A directed opening
// runs through every mode and the corner cases. Random beats follow, aimed at
// a few densely used regions. Each result beat is checked field by field
// against a behavioral copy of the mask matrix.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rrbm_pkg::*;

  // Mode codes the block must treat as no-ops.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  localparam int RANDOM_BEATS = 1600;
  localparam int GAP_MAX      = 10;   // longest idle / stall drawn per beat
  localparam int QUIET_SPAN   = 200;  // every 4th span of beats runs back to back
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOT_REGIONS  = 4;    // regions that take most of the traffic
  localparam int GRID_STEP    = 64;   // spacing of the densely used volumes

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [REGION_W-1:0] region;
    logic [VOLUME_W-1:0] volume;
    logic [BIT_W-1:0]    bitpos;
    logic [MASK_W-1:0]   mask;
  } matrix_op_t;

  typedef struct packed {
    logic [MASK_W-1:0]   mask;
    logic                hit;
    logic [VOLUME_W-1:0] volume;
    logic                found;
  } matrix_res_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic [MODE_W-1:0]   mode_i          = '0;
  logic [REGION_W-1:0] local_region_i  = '0;
  logic [VOLUME_W-1:0] target_volume_i = '0;
  logic [BIT_W-1:0]    target_region_i = '0;
  logic [MASK_W-1:0]   new_mask_i      = '0;
  logic                out_valid_o;
  logic                out_stall_i     = 1'b0;
  logic [MASK_W-1:0]   mask_out_o;
  logic                bit_hit_o;
  logic [VOLUME_W-1:0] volume_out_o;
  logic                volume_found_o;

  always #1 clk_i = ~clk_i;

  region_reference_bit_matrix i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .local_region_i (local_region_i),
    .target_volume_i(target_volume_i),
    .target_region_i(target_region_i),
    .new_mask_i     (new_mask_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mask_out_o     (mask_out_o),
    .bit_hit_o      (bit_hit_o),
    .volume_out_o   (volume_out_o),
    .volume_found_o (volume_found_o)
  );

  // --------------------------------------------------------------------------
  // Behavioral mask matrix. Indexed by {region, volume}; bit type starts at
  // zero, which matches the cleared store after reset.
  // --------------------------------------------------------------------------
  bit [MASK_W-1:0] shadow_masks [REGION_COUNT*VOLUME_COUNT];

  matrix_op_t  op_backlog[$];        // beats not yet offered
  matrix_res_t expected_answers[$];  // one per accepted beat, in order

  int errors        = 0;
  int beats_sent    = 0;
  int results_seen  = 0;
  int hit_count     = 0;
  int found_count   = 0;
  int mode_tally [8];

  // Applies one operation to the matrix and returns the result beat it gives.
  function automatic matrix_res_t apply_op(matrix_op_t op);
    matrix_res_t         res;
    logic [ADDR_W-1:0]   row;
    logic                region_ok;
    logic                pair_ok;
    int                  v;
    res       = '0;
    row       = {op.region, op.volume};
    region_ok = op.region < REGION_COUNT;
    pair_ok   = region_ok && (op.volume < VOLUME_COUNT);
    case (op.mode)
      MODE_SET: begin
        if (pair_ok) shadow_masks[row][op.bitpos] = 1'b1;
      end
      MODE_TEST: begin
        if (pair_ok) res.hit = shadow_masks[row][op.bitpos];
      end
      MODE_READ: begin
        if (pair_ok) res.mask = shadow_masks[row];
      end
      MODE_WRITE: begin
        // a zero mask is the same as no reference
        if (pair_ok) shadow_masks[row] = op.mask;
      end
      MODE_CLEAR: begin
        if (region_ok) begin
          for (v = 0; v < VOLUME_COUNT; v++) shadow_masks[{op.region, VOLUME_W'(v)}] = '0;
        end
      end
      MODE_FIND: begin
        // first non-zero mask at or above the start volume, ascending
        if (pair_ok) begin
          for (v = int'(op.volume); v < VOLUME_COUNT; v++) begin
            if (shadow_masks[{op.region, VOLUME_W'(v)}] != '0) begin
              res.volume = VOLUME_W'(v);
              res.found  = 1'b1;
              break;
            end
          end
        end
      end
      default: ;  // spare modes leave state alone and return all zero
    endcase
    return res;
  endfunction

  function automatic void queue_op(logic [MODE_W-1:0] m, int r, int v, int b,
                                   logic [MASK_W-1:0] mask);
    matrix_op_t op;
    op.mode   = m;
    op.region = REGION_W'(r);
    op.volume = VOLUME_W'(v);
    op.bitpos = BIT_W'(b);
    op.mask   = mask;
    op_backlog.push_back(op);
  endfunction

  // Random beat. Most traffic goes to a few regions and to a grid of volumes
  // so that tests, reads and finds land on populated masks; half of the finds
  // start just below a grid volume to keep the scans short.
  function automatic void queue_random_op();
    int                pick;
    int                r;
    int                v;
    logic [MODE_W-1:0] m;
    logic [MASK_W-1:0] mask;
    pick = $urandom_range(0, 99);
    if (pick < 25)      m = MODE_SET;
    else if (pick < 45) m = MODE_TEST;
    else if (pick < 60) m = MODE_READ;
    else if (pick < 80) m = MODE_WRITE;
    else if (pick < 82) m = MODE_CLEAR;
    else if (pick < 94) m = MODE_FIND;
    else if (pick < 97) m = MODE_SPARE_LO;
    else                m = MODE_SPARE_HI;

    if ($urandom_range(0, 9) < 8) r = $urandom_range(0, HOT_REGIONS-1);
    else                          r = $urandom_range(0, REGION_COUNT-1);

    pick = $urandom_range(0, 9);
    if (m == MODE_FIND) begin
      if (pick < 5)      v = $urandom_range(1, VOLUME_COUNT/GRID_STEP) * GRID_STEP
                             - $urandom_range(1, 8);
      else if (pick < 8) v = $urandom_range(VOLUME_COUNT-GRID_STEP, VOLUME_COUNT-1);
      else               v = $urandom_range(0, VOLUME_COUNT-1);
    end else begin
      if (pick < 6)      v = $urandom_range(0, VOLUME_COUNT/GRID_STEP-1) * GRID_STEP
                             + $urandom_range(0, 3);
      else if (pick < 7) v = ($urandom_range(0, 1) != 0) ? VOLUME_COUNT-1 : 0;
      else               v = $urandom_range(0, VOLUME_COUNT-1);
    end

    case ($urandom_range(0, 7))
      0:       mask = '0;
      1:       mask = '1;
      2, 3:    mask = MASK_W'(1) << $urandom_range(0, MASK_W-1);
      default: mask = {$urandom, $urandom};
    endcase

    queue_op(m, r, v, $urandom_range(0, MASK_W-1), mask);
  endfunction

  // --------------------------------------------------------------------------
  // Input driver. Offers the backlog one beat at a time, with a random idle
  // gap after each beat except during the quiet spans. Prediction happens at
  // the edge that accepts the beat.
  // --------------------------------------------------------------------------
  int         gap_left;
  matrix_op_t next_op;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_answers.push_back(apply_op({mode_i, local_region_i, target_volume_i,
                                             target_region_i, new_mask_i}));
        mode_tally[mode_i]++;
        beats_sent++;
      end
      // payload only moves once the current beat is gone
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (op_backlog.size() > 0) begin
          next_op         = op_backlog.pop_front();
          mode_i          <= next_op.mode;
          local_region_i  <= next_op.region;
          target_volume_i <= next_op.volume;
          target_region_i <= next_op.bitpos;
          new_mask_i      <= next_op.mask;
          in_valid_i      <= 1'b1;
          gap_left        <= (((beats_sent / QUIET_SPAN) % 4) == 3) ? 0
                             : $urandom_range(0, GAP_MAX);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. After each accepted result a stall length is drawn; the
  // stall is held until the next result has waited that many valid cycles.
  // --------------------------------------------------------------------------
  int          stall_left;
  int          stall_draw;
  matrix_res_t want;

  task automatic check_field(string name, logic [MASK_W-1:0] exp_val,
                             logic [MASK_W-1:0] got_val);
    if (got_val !== exp_val) begin
      $display("%t: %s mismatch, expected %h, got %h", $time, name, exp_val, got_val);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      if (expected_answers.size() == 0) begin
        $display("%t: result beat with no outstanding request", $time);
        errors++;
      end else begin
        want = expected_answers.pop_front();
        results_seen++;
        if (want.hit)   hit_count++;
        if (want.found) found_count++;
        check_field("mask_out",     want.mask,                 mask_out_o);
        check_field("bit_hit",      MASK_W'(want.hit),         MASK_W'(bit_hit_o));
        check_field("volume_out",   MASK_W'(want.volume),      MASK_W'(volume_out_o));
        check_field("volume_found", MASK_W'(want.found),       MASK_W'(volume_found_o));
      end
      stall_draw = (((results_seen / QUIET_SPAN) % 4) == 3) ? 0
                   : $urandom_range(0, GAP_MAX);
      stall_left  <= stall_draw;
      out_stall_i <= (stall_draw != 0);
    end else if (out_valid_o && stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int k;

    // Directed opening: cleared store, bit extremes, region and volume
    // extremes, write of zero as removal, spare modes, clear of a region.
    queue_op(MODE_READ,  0, 0, 0, '0);                   // store cleared at reset
    queue_op(MODE_FIND,  0, 0, 0, '0);                   // empty region: no hit
    queue_op(MODE_SET,   0, 0, 0, '0);
    queue_op(MODE_SET,   0, 0, MASK_W-1, '0);
    queue_op(MODE_TEST,  0, 0, 0, '0);
    queue_op(MODE_TEST,  0, 0, MASK_W-1, '0);
    queue_op(MODE_TEST,  0, 0, 1, '0);
    queue_op(MODE_READ,  0, 0, 0, '0);
    queue_op(MODE_WRITE, REGION_COUNT-1, VOLUME_COUNT-1, 0, '1);
    queue_op(MODE_READ,  REGION_COUNT-1, VOLUME_COUNT-1, 0, '0);
    queue_op(MODE_TEST,  REGION_COUNT-1, VOLUME_COUNT-1, 31, '0);
    queue_op(MODE_FIND,  REGION_COUNT-1, 0, 0, '0);      // hit on the last volume
    queue_op(MODE_FIND,  REGION_COUNT-1, VOLUME_COUNT-1, 0, '0);
    queue_op(MODE_WRITE, REGION_COUNT-1, VOLUME_COUNT-1, 0, '0);  // removal
    queue_op(MODE_FIND,  REGION_COUNT-1, VOLUME_COUNT-1, 0, '0);
    queue_op(MODE_READ,  REGION_COUNT-1, VOLUME_COUNT-1, 0, '0);
    queue_op(MODE_WRITE, 5, 512, 0, 64'hA5A5_A5A5_A5A5_A5A5);
    queue_op(MODE_WRITE, 5, 513, 0, 64'h5A5A_5A5A_5A5A_5A5A);
    queue_op(MODE_FIND,  5, 100, 0, '0);
    queue_op(MODE_FIND,  5, 513, 0, '0);
    queue_op(MODE_SPARE_LO, REGION_COUNT-1, VOLUME_COUNT-1, MASK_W-1, '1);
    queue_op(MODE_SPARE_HI, 5, 512, 0, '1);
    queue_op(MODE_CLEAR, 0, VOLUME_COUNT-1, MASK_W-1, '1);
    queue_op(MODE_READ,  0, 0, 0, '0);
    queue_op(MODE_FIND,  0, 0, 0, '0);

    for (k = 0; k < RANDOM_BEATS; k++) queue_random_op();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Backlog drained, last beat taken and every result back.
    do @(negedge clk_i);
    while (op_backlog.size() != 0 || in_valid_i || expected_answers.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Ran %0d beats: %0d set, %0d test, %0d read, %0d write, %0d clear,",
             beats_sent, mode_tally[MODE_SET], mode_tally[MODE_TEST],
             mode_tally[MODE_READ], mode_tally[MODE_WRITE], mode_tally[MODE_CLEAR]);
    $display("  %0d find, %0d spare", mode_tally[MODE_FIND],
             mode_tally[MODE_SPARE_LO] + mode_tally[MODE_SPARE_HI]);
    $display("Checked %0d results: %0d tests hit, %0d finds located a volume, %0d errors",
             results_seen, hit_count, found_count, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run, reset clearing pass included.
  initial begin : watchdog
    #40_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/rrbm_pkg.sv
rtl/core/rrbm_ctrl.sv
rtl/core/rrbm_datapath.sv
rtl/core/region_reference_bit_matrix.sv
tb/tb_top.sv
